/* hw/rtl/stepper_speed_ramp_generator_core_assert.svh */
// assertion macros for the stepper speed ramp generator
// used by the core; no other dependencies
`ifndef STEPPER_SPEED_RAMP_GENERATOR_CORE_ASSERT_SVH
`define STEPPER_SPEED_RAMP_GENERATOR_CORE_ASSERT_SVH

// condition holds in the same cycle
`define SSRG_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("ssrg assertion failed");

// condition holds in the following cycle
`define SSRG_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("ssrg assertion failed");

`endif

/* hw/rtl/ssrg_pkg.sv */
// package for the stepper speed ramp generator
// widths, reset values, register indexes, sequencer states and control bundle
package ssrg_pkg;

    localparam int ELAPSED_W    = 12;
    localparam int CFG_PERIOD_W = 12;
    localparam int DIVISOR_W    = 7;
    localparam int RAMP_W       = 20;
    localparam int PERIOD_W     = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;

    localparam int TIMER_WIDTH_DEF = 32;

    localparam int CNT_W = $clog2(PERIOD_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PERIOD_W - 1);

    localparam logic [CFG_PERIOD_W-1:0] FAST_PERIOD_RST = 12'd40;
    localparam logic [CFG_PERIOD_W-1:0] SLOW_PERIOD_RST = 12'd900;
    localparam logic [CFG_PERIOD_W-1:0] STOP_PERIOD_RST = 12'd2400;
    localparam logic [DIVISOR_W-1:0]    ACCEL_DIV_RST   = 7'd40;
    localparam logic [DIVISOR_W-1:0]    DECEL_DIV_RST   = 7'd100;
    localparam logic [RAMP_W-1:0]       RAMP_INT_RST    = 20'd10000;

    // largest period reachable: twice the largest target less one
    localparam logic [PERIOD_W-1:0] PERIOD_BOUND = 16'd8189;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_PERIOD = 3'd0,
        CFG_SLOW_PERIOD = 3'd1,
        CFG_STOP_PERIOD = 3'd2,
        CFG_ACCEL_DIV   = 3'd3,
        CFG_DECEL_DIV   = 3'd4,
        CFG_RAMP_INT    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_ACC,
        ST_DIV,
        ST_ADJ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic div_load;
        logic div_acc;
        logic div_step;
        logic adj;
        logic commit;
    } t_ctrl;

endpackage

/* hw/rtl/ssrg_tick_if.sv */
// tick request channel: elapsed microseconds and the two mode switches
// depends on ssrg_pkg
interface ssrg_tick_if import ssrg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_us;
    logic                 slow_switch;
    logic                 fast_switch;

    modport source (output valid, elapsed_us, slow_switch, fast_switch, input ready);
    modport sink   (input valid, elapsed_us, slow_switch, fast_switch, output ready);
endinterface

/* hw/rtl/ssrg_step_if.sv */
// step result channel: pulse, driver disable, mode leds and current period
// depends on ssrg_pkg
interface ssrg_step_if import ssrg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                step_pulse;
    logic                driver_disable;
    logic                slow_led;
    logic                fast_led;
    logic [PERIOD_W-1:0] current_period;

    modport source (output valid, step_pulse, driver_disable, slow_led, fast_led,
                    current_period, input ready);
    modport sink   (input valid, step_pulse, driver_disable, slow_led, fast_led,
                    current_period, output ready);
endinterface

/* hw/rtl/stepper_speed_ramp_generator_core.sv */
// stepper speed ramp generator core: timers, ramp sequencer and shared divider
// depends on ssrg_pkg, ssrg_tick_if, ssrg_step_if and the assertion header
//
//  channel   direction  carries
//  i_tick    in         elapsed_us, slow_switch, fast_switch
//  o_step    out        step_pulse, driver_disable, slow_led, fast_led, current_period
//  i_cfg_*   in         register writes, index 0..5
//
// a tick without a ramp update passes ST_IDLE, ST_RAMP and ST_DONE to the result register
// a ramp update adds the ST_ACC compare, and each division adds the ST_DIV steps of the
// restoring divider and one ST_ADJ adjust; deceleration and acceleration may both divide
// the single shared 16-step divider serves every division
// reset is synchronous, active low; a result waiting on o_step stalls the
// final commit, and no new tick request is taken until that commit is made
`include "stepper_speed_ramp_generator_core_assert.svh"

module stepper_speed_ramp_generator_core import ssrg_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssrg_tick_if.sink             i_tick,
    ssrg_step_if.source           o_step,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TW1    = TIMER_WIDTH + 1;
    localparam int RCMP_W = (TIMER_WIDTH > RAMP_W) ? TIMER_WIDTH : RAMP_W;
    localparam int P1_W   = PERIOD_W + 1;

    // configuration registers
    logic [CFG_PERIOD_W-1:0] r_fast_period;
    logic [CFG_PERIOD_W-1:0] r_slow_period;
    logic [CFG_PERIOD_W-1:0] r_stop_period;
    logic [DIVISOR_W-1:0]    r_accel_div;
    logic [DIVISOR_W-1:0]    r_decel_div;
    logic [RAMP_W-1:0]       r_ramp_int;

    // architectural state
    logic [TIMER_WIDTH-1:0]  r_step_timer;
    logic [TIMER_WIDTH-1:0]  r_ramp_timer;
    logic [PERIOD_W-1:0]     r_step_period;
    logic                    r_driver_disabled;

    // per-request working registers
    t_state                  r_state;
    t_state                  n_state;
    logic [CFG_PERIOD_W-1:0] r_target;
    logic                    r_slow;
    logic                    r_fast;
    logic [PERIOD_W-1:0]     r_p;
    logic                    r_upd;

    // shared divider
    logic [PERIOD_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0]    r_rem;
    logic [DIVISOR_W-1:0]    r_div;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_div_acc;

    // result register
    logic                    r_out_valid;
    logic                    r_out_pulse;
    logic                    r_out_disable;
    logic                    r_out_slow;
    logic                    r_out_fast;
    logic [PERIOD_W-1:0]     r_out_period;

    t_ctrl                   ctrl;

    logic [TW1-1:0]          step_sum;
    logic [TW1-1:0]          ramp_sum;
    logic                    ramp_hit;
    logic                    p_lt_target;
    logic                    p_gt_target;
    logic [DIVISOR_W:0]      trial;
    logic                    trial_ge;
    logic [DIVISOR_W-1:0]    div_sel;
    logic [P1_W-1:0]         grow_sum;
    logic [P1_W-1:0]         v_plus2;
    logic [P1_W-1:0]         clamp_lim;
    logic [P1_W-1:0]         shrink_dec;
    logic [P1_W-1:0]         p_ext;
    logic [PERIOD_W-1:0]     adj_p;
    logic [PERIOD_W-1:0]     per_new;
    logic                    disable_new;
    logic                    pulse_new;

    assign step_sum    = {1'b0, r_step_timer} + TW1'(i_tick.elapsed_us);
    assign ramp_sum    = {1'b0, r_ramp_timer} + TW1'(i_tick.elapsed_us);
    assign ramp_hit    = RCMP_W'(r_ramp_timer) > RCMP_W'(r_ramp_int);
    assign p_lt_target = r_p < PERIOD_W'(r_target);
    assign p_gt_target = r_p > PERIOD_W'(r_target);

    // divider step: one compare and subtract per cycle
    assign trial    = {r_rem, r_quo[PERIOD_W-1]};
    assign trial_ge = trial >= {1'b0, r_div};
    assign div_sel  = ctrl.div_acc ? r_accel_div : r_decel_div;

    // adjust after a division, r_quo holds the quotient
    assign p_ext      = {1'b0, r_p};
    assign grow_sum   = p_ext + P1_W'(r_quo) + P1_W'(1);
    assign v_plus2    = P1_W'(r_quo) + P1_W'(2);
    assign clamp_lim  = P1_W'(r_stop_period) - v_plus2;
    assign shrink_dec = P1_W'(r_quo) + P1_W'(1);

    always_comb begin
        if (r_div_acc) begin
            if (shrink_dec >= p_ext) begin
                adj_p = '0;
            end else begin
                adj_p = PERIOD_W'(p_ext - shrink_dec);
            end
        end else begin
            if (v_plus2 <= P1_W'(r_stop_period) && grow_sum > clamp_lim) begin
                adj_p = PERIOD_W'(r_stop_period);
            end else begin
                adj_p = PERIOD_W'(grow_sum);
            end
        end
    end

    assign per_new     = r_upd ? r_p : r_step_period;
    assign disable_new = r_upd ? (r_p == PERIOD_W'(r_stop_period)) : r_driver_disabled;
    assign pulse_new   = r_step_timer > TIMER_WIDTH'(per_new);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_tick.valid) begin
                    n_state = ST_RAMP;
                end
            end
            ST_RAMP: begin
                if (!ramp_hit) begin
                    n_state = ST_DONE;
                end else if (p_lt_target) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (p_gt_target) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_ADJ;
                end
            end
            ST_ADJ: begin
                n_state = r_div_acc ? ST_DONE : ST_ACC;
            end
            ST_DONE: begin
                if (!r_out_valid || o_step.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE: ctrl.in_ready = 1'b1;
            ST_RAMP: ctrl.div_load = ramp_hit && p_lt_target;
            ST_ACC: begin
                ctrl.div_load = p_gt_target;
                ctrl.div_acc  = 1'b1;
            end
            ST_DIV:  ctrl.div_step = 1'b1;
            ST_ADJ:  ctrl.adj      = 1'b1;
            ST_DONE: ctrl.commit   = !r_out_valid || o_step.ready;
            default: ctrl = '0;
        endcase
    end

    assign i_tick.ready          = ctrl.in_ready;
    assign o_step.valid          = r_out_valid;
    assign o_step.step_pulse     = r_out_pulse;
    assign o_step.driver_disable = r_out_disable;
    assign o_step.slow_led       = r_out_slow;
    assign o_step.fast_led       = r_out_fast;
    assign o_step.current_period = r_out_period;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_period <= FAST_PERIOD_RST;
            r_slow_period <= SLOW_PERIOD_RST;
            r_stop_period <= STOP_PERIOD_RST;
            r_accel_div   <= ACCEL_DIV_RST;
            r_decel_div   <= DECEL_DIV_RST;
            r_ramp_int    <= RAMP_INT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FAST_PERIOD: r_fast_period <= i_cfg_data[CFG_PERIOD_W-1:0];
                CFG_SLOW_PERIOD: r_slow_period <= i_cfg_data[CFG_PERIOD_W-1:0];
                CFG_STOP_PERIOD: r_stop_period <= i_cfg_data[CFG_PERIOD_W-1:0];
                CFG_ACCEL_DIV:   r_accel_div   <= i_cfg_data[DIVISOR_W-1:0];
                CFG_DECEL_DIV:   r_decel_div   <= i_cfg_data[DIVISOR_W-1:0];
                CFG_RAMP_INT:    r_ramp_int    <= i_cfg_data[RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_step_timer      <= '0;
            r_ramp_timer      <= '0;
            r_step_period     <= PERIOD_W'(STOP_PERIOD_RST);
            r_driver_disabled <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctrl.in_ready && i_tick.valid) begin
                r_step_timer <= step_sum[TIMER_WIDTH] ? '1 : step_sum[TIMER_WIDTH-1:0];
                r_ramp_timer <= ramp_sum[TIMER_WIDTH] ? '1 : ramp_sum[TIMER_WIDTH-1:0];
            end
            if (ctrl.commit) begin
                r_out_valid <= 1'b1;
                if (r_upd) begin
                    r_step_period     <= r_p;
                    r_driver_disabled <= disable_new;
                    r_ramp_timer      <= '0;
                end
                if (pulse_new) begin
                    r_step_timer <= '0;
                end
            end else if (o_step.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        if (ctrl.in_ready && i_tick.valid) begin
            r_slow <= i_tick.slow_switch;
            r_fast <= i_tick.fast_switch && !i_tick.slow_switch;
            r_p    <= r_step_period;
            if (i_tick.slow_switch) begin
                r_target <= r_slow_period;
            end else if (i_tick.fast_switch) begin
                r_target <= r_fast_period;
            end else begin
                r_target <= r_stop_period;
            end
        end
        if (r_state == ST_RAMP) begin
            r_upd <= ramp_hit;
        end
        if (ctrl.div_load) begin
            r_quo     <= r_p;
            r_rem     <= '0;
            r_cnt     <= '0;
            r_div_acc <= ctrl.div_acc;
            r_div     <= (div_sel == '0) ? DIVISOR_W'(1) : div_sel;
        end else if (ctrl.div_step) begin
            r_quo <= {r_quo[PERIOD_W-2:0], trial_ge};
            r_rem <= trial_ge ? DIVISOR_W'(trial - {1'b0, r_div}) : trial[DIVISOR_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (ctrl.adj) begin
            r_p <= adj_p;
        end
        if (ctrl.commit) begin
            r_out_pulse   <= pulse_new;
            r_out_disable <= disable_new;
            r_out_slow    <= r_slow;
            r_out_fast    <= r_fast;
            r_out_period  <= per_new;
        end
    end

    `SSRG_ASSERT_NXT(a_div_ends, i_clk, i_rst_n,
        r_state == ST_DIV && r_cnt == DIV_LAST, r_state == ST_ADJ)
    `SSRG_ASSERT_IMP(a_period_bound, i_clk, i_rst_n,
        1'b1, r_step_period <= PERIOD_BOUND)
    `SSRG_ASSERT_NXT(a_disable_match, i_clk, i_rst_n, ctrl.commit && r_upd,
        r_out_disable == (r_step_period == PERIOD_W'(r_stop_period)))
    `SSRG_ASSERT_NXT(a_pulse_clears, i_clk, i_rst_n,
        ctrl.commit && pulse_new, r_step_timer == '0 && r_out_pulse)

endmodule
